>>> hdl/wsdf_pkg.sv
// ----------------------------------------------------------------------------
// wsdf_pkg
// Shared types, codes and helpers of the websocket frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package wsdf_pkg;

    // parser phase
    typedef enum logic [2:0] {
        PH_HDR0 = 3'd0,
        PH_HDR1 = 3'd1,
        PH_EXT  = 3'd2,
        PH_KEY  = 3'd3,
        PH_DATA = 3'd4
    } phase_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_CLOSE   = 2'd1,
        ST_UNSUP   = 2'd2,
        ST_TOOLONG = 2'd3
    } status_t;

    // opcodes with special meaning
    localparam logic [3:0] OP_CONT  = 4'd0;
    localparam logic [3:0] OP_TEXT  = 4'd1;
    localparam logic [3:0] OP_BIN   = 4'd2;
    localparam logic [3:0] OP_CLOSE = 4'd8;
    localparam logic [3:0] OP_PING  = 4'd9;
    localparam logic [3:0] OP_PONG  = 4'd10;

    // 7-bit length escapes
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    // register map
    localparam int          CFG_ADDR_W      = 3;
    localparam logic        REG_MAX_PAYLOAD = 1'b0;
    localparam logic [31:0] MAX_PAYLOAD_RST = 32'd1048576;

    // one result
    typedef struct packed {
        status_t    status;
        logic       frame_end;
        logic [3:0] frame_opcode;
        logic       is_text;
        logic       has_data;
        logic [7:0] data_byte;
    } result_t;

    // opcodes whose payload is forwarded
    function automatic logic op_passes(input logic [3:0] op);
        op_passes = (op == OP_CONT) || (op == OP_TEXT) || (op == OP_BIN) ||
                    (op == OP_PING) || (op == OP_PONG);
    endfunction

    // status closing a frame of this opcode
    function automatic status_t done_status(input logic [3:0] op);
        if (op == OP_CLOSE) begin
            done_status = ST_CLOSE;
        end else if (!op_passes(op)) begin
            done_status = ST_UNSUP;
        end else begin
            done_status = ST_OK;
        end
    endfunction

endpackage

`default_nettype wire

>>> hdl/websocket_frame_deframer.sv
// Path: an accepted byte is held in the input register, parsed combinationally
// when it advances, and its result is registered onto m_*.
// Throughput: one byte per cycle while the output register is empty or being
// taken; the input register advances only then, so the parser stalls otherwise.
// Reset (aresetn low, synchronous): clears both valid flags, the parser state
// and the halt flag, and loads the length limit with 1048576.
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Parses a received byte stream into websocket frames and emits unmasked
// payload bytes, frame ends and status results.
// ----------------------------------------------------------------------------
`default_nettype none

module websocket_frame_deframer (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // input byte stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [7:0]                      s_tdata,   // [7:0] rx_byte
    // result stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [7:0]                           m_tdata,   // [7:0] data_byte
    output logic                                 m_tlast,   // frame_end
    // [0] has_data, [1] is_text, [5:2] frame_opcode, [7:6] status
    output logic [7:0]                           m_tuser,
    // configuration
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [wsdf_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                     pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);

    logic              in_valid_reg;
    logic [7:0]        in_data_reg;
    logic              out_valid_reg;
    wsdf_pkg::result_t out_res_reg;
    logic              advance;
    logic              res_valid;
    wsdf_pkg::result_t res;
    logic [31:0]       max_payload_len;

    wsdf_cfg u_cfg (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .max_payload_len (max_payload_len)
    );

    // Advance the held byte into the parser when the result slot frees up.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Hold the accepted request until the parser consumes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
        end
    end

    wsdf_parser u_parser (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .step            (advance),
        .rx_byte         (in_data_reg),
        .max_payload_len (max_payload_len),
        .res_valid       (res_valid),
        .res             (res)
    );

    // Load a result on advance; drop it once the sink takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= res_valid;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_res_reg.data_byte;
    assign m_tlast  = out_res_reg.frame_end;
    assign m_tuser  = {out_res_reg.status, out_res_reg.frame_opcode,
                       out_res_reg.is_text, out_res_reg.has_data};

endmodule

`default_nettype wire

>>> hdl/wsdf_cfg.sv
// ----------------------------------------------------------------------------
// wsdf_cfg
// APB register file: holds the payload length limit.
// ----------------------------------------------------------------------------
`default_nettype none

module wsdf_cfg (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [wsdf_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                     pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,
    output logic [31:0]                          max_payload_len
);

    logic        max_len_sel;
    logic [31:0] max_payload_reg;
    logic        wr_hit;

    assign pready = 1'b1;
    assign max_len_sel = (paddr[2] == wsdf_pkg::REG_MAX_PAYLOAD);
    assign wr_hit = psel && penable && pwrite && pready && max_len_sel;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_payload_reg <= wsdf_pkg::MAX_PAYLOAD_RST;
        end else if (wr_hit) begin
            max_payload_reg <= pwdata;
        end
    end

    assign prdata = max_len_sel ? max_payload_reg : 32'd0;
    assign max_payload_len = max_payload_reg;

endmodule

`default_nettype wire

>>> hdl/wsdf_parser.sv
// ----------------------------------------------------------------------------
// wsdf_parser
// Frame parser state and its single-pass next-state and result logic.
// ----------------------------------------------------------------------------
`default_nettype none

module wsdf_parser (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            step,
    input  wire logic [7:0]      rx_byte,
    input  wire logic [31:0]     max_payload_len,
    output logic                 res_valid,
    output wsdf_pkg::result_t    res
);

    wsdf_pkg::phase_t phase_reg, phase_next;
    logic [3:0]       opcode_reg, opcode_next;
    logic             mask_on_reg, mask_on_next;
    logic [63:0]      length_reg, length_next;
    logic [2:0]       cnt_reg, cnt_next;
    logic [31:0]      key_reg, key_next;
    logic [31:0]      index_reg, index_next;
    logic             halted_reg, halted_next;

    logic [6:0]  len7;
    logic        len_escape;
    logic [63:0] len_new;
    logic        is_known;
    logic        key_done;
    logic        data_last;
    logic        over;
    logic        mask_new;
    logic        go_key;
    logic        go_start;
    logic        zero_len;
    logic        go_done;
    logic        emit_data;
    logic        passes;
    logic        act;
    logic [7:0]  key_byte;
    wsdf_pkg::status_t st_done;

    assign len7       = rx_byte[6:0];
    assign len_escape = (len7 == wsdf_pkg::LEN_EXT16) || (len7 == wsdf_pkg::LEN_EXT64);
    assign passes     = wsdf_pkg::op_passes(opcode_reg);
    assign st_done    = wsdf_pkg::done_status(opcode_reg);
    assign act        = step && !halted_reg;

    // decode what this byte completes
    always_comb begin
        len_new   = length_reg;
        is_known  = 1'b0;
        key_done  = 1'b0;
        data_last = 1'b0;
        case (phase_reg)
            wsdf_pkg::PH_HDR1: begin
                len_new  = len_escape ? 64'd0 : {57'd0, len7};
                is_known = !len_escape;
            end
            wsdf_pkg::PH_EXT: begin
                len_new  = {length_reg[55:0], rx_byte};
                is_known = (cnt_reg == 3'd0);
            end
            wsdf_pkg::PH_KEY: begin
                key_done = (cnt_reg == 3'd0);
            end
            wsdf_pkg::PH_DATA: begin
                data_last = (({1'b0, index_reg} + 33'd1) >= {1'b0, length_reg[31:0]});
            end
            default: begin
            end
        endcase
    end

    assign over      = act && is_known &&
                       ((|len_new[63:32]) || (len_new[31:0] > max_payload_len));
    assign mask_new  = (phase_reg == wsdf_pkg::PH_HDR1) ? rx_byte[7] : mask_on_reg;
    assign go_key    = act && is_known && !over && mask_new;
    assign go_start  = act && ((is_known && !over && !mask_new) || key_done);
    assign zero_len  = ~(|len_new);
    assign go_done   = (go_start && zero_len) || (act && data_last && !passes);
    assign emit_data = act && (phase_reg == wsdf_pkg::PH_DATA) && passes;

    // mask key byte for this payload position, first key byte first
    always_comb begin
        case (index_reg[1:0])
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
        if (!mask_on_reg) begin
            key_byte = 8'd0;
        end
    end

    // next state
    always_comb begin
        phase_next   = phase_reg;
        opcode_next  = opcode_reg;
        mask_on_next = mask_on_reg;
        length_next  = length_reg;
        cnt_next     = cnt_reg;
        key_next     = key_reg;
        index_next   = index_reg;
        halted_next  = halted_reg;
        if (act) begin
            length_next  = len_new;
            mask_on_next = mask_new;
            case (phase_reg)
                wsdf_pkg::PH_HDR0: begin
                    opcode_next = rx_byte[3:0];
                    phase_next  = wsdf_pkg::PH_HDR1;
                end
                wsdf_pkg::PH_HDR1: begin
                    if (len_escape) begin
                        cnt_next   = (len7 == wsdf_pkg::LEN_EXT16) ? 3'd1 : 3'd7;
                        phase_next = wsdf_pkg::PH_EXT;
                    end
                end
                wsdf_pkg::PH_EXT: begin
                    if (cnt_reg != 3'd0) begin
                        cnt_next = cnt_reg - 3'd1;
                    end
                end
                wsdf_pkg::PH_KEY: begin
                    key_next = {key_reg[23:0], rx_byte};
                    if (cnt_reg != 3'd0) begin
                        cnt_next = cnt_reg - 3'd1;
                    end
                end
                wsdf_pkg::PH_DATA: begin
                    index_next = index_reg + 32'd1;
                    if (data_last) begin
                        phase_next = wsdf_pkg::PH_HDR0;
                    end
                end
                default: begin
                    phase_next = wsdf_pkg::PH_HDR0;
                end
            endcase
            if (is_known && !over) begin
                key_next = 32'd0;
            end
            if (go_key) begin
                cnt_next   = 3'd3;
                phase_next = wsdf_pkg::PH_KEY;
            end
            if (go_start) begin
                index_next = 32'd0;
                phase_next = zero_len ? wsdf_pkg::PH_HDR0 : wsdf_pkg::PH_DATA;
            end
            if (over) begin
                halted_next = 1'b1;
                phase_next  = wsdf_pkg::PH_HDR0;
            end
            if (go_done && (st_done != wsdf_pkg::ST_OK)) begin
                halted_next = 1'b1;
            end
        end
    end

    // result
    always_comb begin
        res_valid        = over || go_done || emit_data;
        res.data_byte    = 8'd0;
        res.has_data     = 1'b0;
        res.is_text      = (opcode_reg == wsdf_pkg::OP_TEXT);
        res.frame_opcode = opcode_reg;
        res.frame_end    = 1'b1;
        res.status       = wsdf_pkg::ST_OK;
        if (over) begin
            res.status = wsdf_pkg::ST_TOOLONG;
        end else if (go_done) begin
            res.status = st_done;
        end else if (emit_data) begin
            res.data_byte = rx_byte ^ key_byte;
            res.has_data  = 1'b1;
            res.frame_end = data_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= wsdf_pkg::PH_HDR0;
            opcode_reg  <= 4'd0;
            mask_on_reg <= 1'b0;
            length_reg  <= 64'd0;
            cnt_reg     <= 3'd0;
            key_reg     <= 32'd0;
            index_reg   <= 32'd0;
            halted_reg  <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            opcode_reg  <= opcode_next;
            mask_on_reg <= mask_on_next;
            length_reg  <= length_next;
            cnt_reg     <= cnt_next;
            key_reg     <= key_next;
            index_reg   <= index_next;
            halted_reg  <= halted_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/wsdf_checker.sv
// ----------------------------------------------------------------------------
// wsdf_checker
// Port-level checks of the deframer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module wsdf_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast,
    input wire logic [7:0] m_tuser
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
        $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled result changed");

    // payload bytes always carry ok status
    a_data_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tuser[7:6] == wsdf_pkg::ST_OK)
        else $error("payload byte with error status");

    // a result without data closes a frame and carries a zero byte
    a_nodata_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tlast && m_tdata == 8'd0)
        else $error("status result malformed");

    // text flag follows the opcode
    a_text: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser[1] == (m_tuser[5:2] == wsdf_pkg::OP_TEXT))
        else $error("text flag mismatch");

    // nothing follows an error status
    a_halt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tuser[7:6] != wsdf_pkg::ST_OK |=> !m_tvalid)
        else $error("result after halt");

endmodule

bind websocket_frame_deframer wsdf_checker u_wsdf_checker (.*);

`default_nettype wire

>>> tb/sv/tb_websocket_frame_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_websocket_frame_deframer
// Self-checking bench for the websocket frame deframer: streams well-formed
// frames with random opcodes, lengths, length forms, mask keys and payloads
// through the byte port, predicts every result in a scoreboard and checks the
// result stream field by field. Runs several length limits, random idling on
// both sides, a long receiver hold-off and one halting frame at the very end.
// ----------------------------------------------------------------------------
module tb_websocket_frame_deframer;
    import wsdf_pkg::*;

    typedef enum int {FORM_7, FORM_16, FORM_64} len_form_t;
    typedef enum int {BODY_HEADER_ONLY, BODY_RANDOM, BODY_EXTREME} body_t;

    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 6;
    localparam int RANDOM_BYTES  = 1850;
    localparam int PHASE_BYTES   = 230;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int REPORT_MAX    = 10;

    // ------------------------------------------------------------------------
    // Scoreboard: tracks the parser state of the block, queues the results
    // each accepted byte should cause and matches them against the output.
    // ------------------------------------------------------------------------
    class frame_tracker;
        logic [31:0] limit;
        phase_t      ph;
        logic [3:0]  op;
        logic        masked;
        logic [63:0] len_acc;
        logic [2:0]  left;
        logic [31:0] key;
        logic [31:0] idx;
        logic        stopped;
        result_t     due_results[$];
        int unsigned errors;

        function new();
            limit   = MAX_PAYLOAD_RST;
            ph      = PH_HDR0;
            op      = '0;
            masked  = 1'b0;
            len_acc = '0;
            left    = '0;
            key     = '0;
            idx     = '0;
            stopped = 1'b0;
            errors  = 0;
        endfunction

        // opcodes whose payload bytes come out
        static function logic forwarded(input logic [3:0] code);
            return code == OP_CONT || code == OP_TEXT || code == OP_BIN ||
                   code == OP_PING || code == OP_PONG;
        endfunction

        function void push(input logic [7:0] data, input logic has, input logic at_end,
                           input status_t st);
            result_t r;
            r.data_byte    = data;
            r.has_data     = has;
            r.is_text      = (op == OP_TEXT);
            r.frame_opcode = op;
            r.frame_end    = at_end;
            r.status       = st;
            due_results.insert(due_results.size(), r);
        endfunction

        // end a frame: close or unsupported opcodes report their status and halt the parser, others report ok
        function void close_frame();
            ph = PH_HDR0;
            if (op == OP_CLOSE) begin
                stopped = 1'b1;
                push(8'h00, 1'b0, 1'b1, ST_CLOSE);
            end else if (!forwarded(op)) begin
                stopped = 1'b1;
                push(8'h00, 1'b0, 1'b1, ST_UNSUP);
            end else begin
                push(8'h00, 1'b0, 1'b1, ST_OK);
            end
        endfunction

        function void open_payload();
            idx = '0;
            if (len_acc == 64'd0) begin
                close_frame();
            end else begin
                ph = PH_DATA;
            end
        endfunction

        function void length_ready();
            if (len_acc > {32'h0, limit}) begin
                stopped = 1'b1;
                ph      = PH_HDR0;
                push(8'h00, 1'b0, 1'b1, ST_TOOLONG);
            end else begin
                key = '0;
                if (masked) begin
                    left = 3'd3;
                    ph   = PH_KEY;
                end else begin
                    open_payload();
                end
            end
        endfunction

        function void take_rx_byte(input logic [7:0] b);
            logic [6:0] len7;
            logic [7:0] k;
            logic       at_end;
            if (stopped) return;
            case (ph)
                PH_HDR0: begin
                    op = b[3:0];
                    ph = PH_HDR1;
                end
                PH_HDR1: begin
                    masked  = b[7];
                    len7    = b[6:0];
                    len_acc = '0;
                    if (len7 == LEN_EXT16) begin
                        left = 3'd1;
                        ph   = PH_EXT;
                    end else if (len7 == LEN_EXT64) begin
                        left = 3'd7;
                        ph   = PH_EXT;
                    end else begin
                        len_acc = {57'h0, len7};
                        length_ready();
                    end
                end
                PH_EXT: begin
                    len_acc = {len_acc[55:0], b};
                    if (left == 3'd0) begin
                        length_ready();
                    end else begin
                        left = left - 3'd1;
                    end
                end
                PH_KEY: begin
                    key = {key[23:0], b};
                    if (left == 3'd0) begin
                        open_payload();
                    end else begin
                        left = left - 3'd1;
                    end
                end
                PH_DATA: begin
                    // key bytes apply in arrival order, first one to index 0
                    k      = masked ? key[8 * (3 - idx[1:0]) +: 8] : 8'h00;
                    at_end = ({32'h0, idx} + 64'd1) >= len_acc;
                    idx    = idx + 32'd1;
                    if (!forwarded(op)) begin
                        if (at_end) close_frame();
                    end else begin
                        if (at_end) ph = PH_HDR0;
                        push(b ^ k, 1'b1, at_end, ST_OK);
                    end
                end
                default: ph = PH_HDR0;
            endcase
        endfunction

        function void match_result(input logic [7:0] tdata, input logic tlast,
                                   input logic [7:0] tuser);
            result_t want;
            if (due_results.size() == 0) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("unexpected result: tdata %02h tlast %0b tuser %02h",
                             tdata, tlast, tuser);
                return;
            end
            want = due_results.pop_front();
            if (tdata !== want.data_byte || tuser[0] !== want.has_data ||
                tuser[1] !== want.is_text || tuser[5:2] !== want.frame_opcode ||
                tlast !== want.frame_end || tuser[7:6] !== want.status) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display({"result mismatch: expected data %02h has %0b text %0b op %0h ",
                              "end %0b status %0d, got data %02h has %0b text %0b op %0h ",
                              "end %0b status %0d"},
                             want.data_byte, want.has_data, want.is_text, want.frame_opcode,
                             want.frame_end, want.status, tdata, tuser[0], tuser[1],
                             tuser[5:2], tlast, tuser[7:6]);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------------
    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata  = 8'h00;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [7:0]            m_tdata;
    logic                  m_tlast;
    logic [7:0]            m_tuser;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr    = '0;
    logic [31:0]           pwdata   = 32'h0;
    logic [31:0]           prdata;
    logic                  pready;

    frame_tracker tracker;
    int unsigned  bytes_sent    = 0;
    int unsigned  cycle_count   = 0;
    int           send_gap_pct  = 33;
    int           take_gap_pct  = 33;
    int unsigned  hold_ticket   = 0;
    int unsigned  hold_served   = 0;
    int unsigned  hold_left     = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    websocket_frame_deframer u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // ------------------------------------------------------------------------
    // Monitors: note every accepted byte request, check every accepted result.
    // Values read here are the ones present at the edge.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) tracker.take_rx_byte(s_tdata);
        if (aresetn && m_tvalid && m_tready) tracker.match_result(m_tdata, m_tlast, m_tuser);
    end

    // Abort a hung run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Receiver: stall at random; on a new hold ticket, hold off for a long
    // stretch so the block fills up and drops s_tready.
    always @(posedge aclk) begin
        if (hold_ticket != hold_served) begin
            hold_served = hold_ticket;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= take_gap_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Drivers. Every task starts and ends right after a rising edge.
    // ------------------------------------------------------------------------

    // Offer one byte request, idling at random first; hold it until taken.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
    endtask

    // Write the length limit through the setup and access cycles.
    task automatic write_limit(input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(4 * int'(REG_MAX_PAYLOAD));
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.limit = value;
    endtask

    // Drop valid, drain all expected results, then let trailing header
    // bytes (which give no result) clear the pipeline.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (tracker.due_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic len_form_t pick_form(input logic [63:0] len);
        if (len > 64'd65535) return FORM_64;
        if (len > 64'd125) return ($urandom_range(1) != 0) ? FORM_16 : FORM_64;
        case ($urandom_range(9))
            0, 1:    return FORM_16;
            2:       return FORM_64;
            default: return FORM_7;
        endcase
    endfunction

    // Send one frame: header with random FIN/RSV bits, length in the given
    // form, mask key when masked, then the payload unless header only.
    task automatic send_frame(input logic [3:0] op, input logic [63:0] len,
                              input logic masked, input len_form_t form, input body_t body);
        logic [31:0] key;
        logic [63:0] n;
        key = $urandom;
        send_byte({4'($urandom), op});
        case (form)
            FORM_7: begin
                send_byte({masked, len[6:0]});
            end
            FORM_16: begin
                send_byte({masked, LEN_EXT16});
                send_byte(len[15:8]);
                send_byte(len[7:0]);
            end
            default: begin
                send_byte({masked, LEN_EXT64});
                for (int i = 7; i >= 0; i--) send_byte(len[8 * i +: 8]);
            end
        endcase
        if (body == BODY_HEADER_ONLY) return;
        if (masked) begin
            for (int i = 3; i >= 0; i--) send_byte(key[8 * i +: 8]);
        end
        for (n = 64'd0; n < len; n++) begin
            if (body == BODY_EXTREME) begin
                send_byte(n[0] ? 8'hFF : 8'h00);
            end else begin
                send_byte(8'($urandom));
            end
        end
    endtask

    // Random forwarded frame whose length never exceeds the limit.
    task automatic random_frame(input logic [31:0] lim);
        logic [3:0]  op;
        logic [63:0] len;
        int          r;
        case ($urandom_range(4))
            0:       op = OP_CONT;
            1:       op = OP_TEXT;
            2:       op = OP_BIN;
            3:       op = OP_PING;
            default: op = OP_PONG;
        endcase
        r = $urandom_range(99);
        if (r < 15) begin
            len = 64'd0;
        end else if (r < 90) begin
            len = 64'($urandom_range(1, 12));
        end else begin
            len = 64'($urandom_range(126, 200));
        end
        if (len > {32'h0, lim}) len = {32'h0, lim};
        send_frame(op, len, 1'($urandom_range(1)), pick_form(len), BODY_RANDOM);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [31:0] lim;
        logic [63:0] len;
        logic [3:0]  op;
        int          phase_no;
        int unsigned phase_start;
        tracker = new();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed frames under the reset limit: zero-length text, each
        // length form, masked and unmasked, payload bytes at both extremes.
        lim = MAX_PAYLOAD_RST;
        send_frame(OP_TEXT, 64'd0, 1'b0, FORM_7, BODY_RANDOM);
        send_frame(OP_PONG, 64'd2, 1'b0, FORM_16, BODY_EXTREME);
        send_frame(OP_PING, 64'd5, 1'b1, FORM_7, BODY_EXTREME);
        send_frame(OP_CONT, 64'd1, 1'b0, FORM_64, BODY_EXTREME);
        settle();

        // Random phases, each under its own limit; a limit of zero allows
        // only zero-length frames, small limits hit length == limit often.
        phase_no = 0;
        while (bytes_sent < RANDOM_BYTES) begin
            case (phase_no % 5)
                0:       lim = 32'hFFFF_FFFF;
                1:       lim = 32'h0;
                2:       lim = $urandom_range(1, 20);
                3:       lim = MAX_PAYLOAD_RST;
                default: lim = $urandom_range(126, 300);
            endcase
            // one phase without any idling on either side
            send_gap_pct = (phase_no == 2) ? 0 : 33;
            take_gap_pct = (phase_no == 2) ? 0 : 33;
            write_limit(lim);
            if (phase_no == 3) begin
                // keep offering requests while the receiver holds off
                send_gap_pct = 0;
                hold_ticket++;
            end
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES && bytes_sent < RANDOM_BYTES)
                random_frame(lim);
            settle();
            phase_no++;
        end
        send_gap_pct = 33;
        take_gap_pct = 33;

        // One halting frame to finish: close, unsupported opcode or a length
        // over the limit. The block then ignores all further bytes.
        len = 64'($urandom_range(0, 6));
        if (len > {32'h0, lim}) len = {32'h0, lim};
        case ($urandom_range(2))
            0: begin
                send_frame(OP_CLOSE, len, 1'($urandom_range(1)), pick_form(len), BODY_RANDOM);
            end
            1: begin
                do op = 4'($urandom); while (frame_tracker::forwarded(op) || op == OP_CLOSE);
                send_frame(op, len, 1'($urandom_range(1)), pick_form(len), BODY_RANDOM);
            end
            default: begin
                if ($urandom_range(1) != 0) begin
                    len = {32'h0, lim} + 64'd1;
                end else begin
                    len = {$urandom | 32'h1, $urandom};
                end
                send_frame(4'($urandom), len, 1'($urandom_range(1)), pick_form(len),
                           BODY_HEADER_ONLY);
            end
        endcase
        repeat (6) send_byte(8'($urandom));

        // Drain, then give late or stray results time to show up.
        s_tvalid <= 1'b0;
        while (tracker.due_results.size() != 0) @(posedge aclk);
        repeat (2 * SETTLE_CYCLES) @(posedge aclk);
        if (tracker.errors == 0 && tracker.due_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
